// ===== sv/lfb_pkg.sv =====
// Shared types and constants for the letterbox fit unit.
package lfb_pkg;

	localparam int DIM_BITS = 16;
	localparam int POS_BITS = DIM_BITS + 1;
	localparam int PROD_BITS = 2 * DIM_BITS;
	localparam int DIV_STEP = 4;
	localparam int DIV_STAGES = (DIM_BITS + DIV_STEP - 1) / DIV_STEP;

	localparam logic KIND_PICTURE = 1'b0;
	localparam logic KIND_BAR = 1'b1;

	localparam int MASK_PIC = 0;
	localparam int MASK_TOP = 1;
	localparam int MASK_BOTTOM = 2;
	localparam int MASK_LEFT = 3;
	localparam int MASK_RIGHT = 4;
	localparam int MASK_BITS = 5;

	typedef struct packed {
		logic [DIM_BITS-1:0] mon_x;
		logic [DIM_BITS-1:0] mon_y;
		logic [DIM_BITS-1:0] mon_width;
		logic [DIM_BITS-1:0] mon_height;
		logic [DIM_BITS-1:0] src_width;
		logic [DIM_BITS-1:0] src_height;
	} in_item_t;

	typedef struct packed {
		logic                kind;
		logic [POS_BITS-1:0] rect_x;
		logic [POS_BITS-1:0] rect_y;
		logic [DIM_BITS-1:0] rect_width;
		logic [DIM_BITS-1:0] rect_height;
		logic                last;
	} out_item_t;

	typedef struct packed {
		logic [DIM_BITS-1:0] mx;
		logic [DIM_BITS-1:0] my;
		logic [DIM_BITS-1:0] mw;
		logic [DIM_BITS-1:0] mh;
		logic [DIM_BITS-1:0] sw;
		logic [DIM_BITS-1:0] sh;
		logic                scale;
		logic                wlim;
	} geo_t;

	typedef struct packed {
		geo_t                g;
		logic [DIM_BITS-1:0] d;
		logic [DIM_BITS-1:0] rem;
		logic [DIM_BITS-1:0] low;
		logic [DIM_BITS-1:0] quo;
	} div_t;

	typedef struct packed {
		logic [DIM_BITS-1:0] mx;
		logic [DIM_BITS-1:0] my;
		logic [DIM_BITS-1:0] mw;
		logic [DIM_BITS-1:0] mh;
		logic [DIM_BITS-1:0] w;
		logic [DIM_BITS-1:0] h;
	} size_t;

	typedef struct packed {
		logic [DIM_BITS-1:0]  mx;
		logic [DIM_BITS-1:0]  my;
		logic [DIM_BITS-1:0]  mw;
		logic [POS_BITS-1:0]  px;
		logic [POS_BITS-1:0]  py;
		logic [DIM_BITS-1:0]  w;
		logic [DIM_BITS-1:0]  h;
		logic [DIM_BITS-1:0]  tpad;
		logic [DIM_BITS-1:0]  bpad;
		logic [DIM_BITS-1:0]  lpad;
		logic [DIM_BITS-1:0]  rpad;
		logic [POS_BITS-1:0]  ybot;
		logic [POS_BITS-1:0]  xr;
		logic [MASK_BITS-1:0] mask;
	} emit_t;

endpackage

// ===== sv/letterbox_fit_with_bars_unit.sv =====
// Letterbox fit of a picture into a monitor rectangle, emitting picture and fill bars.
// The first rectangle passes through registered stages for multiply, select,
// 4 divider stages of 4 quotient bits, clamp, geometry, emit and output.
// Throughput: one rectangle per cycle while rect_stall is low; an item yields 1 to 5
// rectangles, all sent by the single emit stage, the picture first and then each bar.
// Reset clears all valid bits; the pipeline starts empty and needs no clearing pass.
module letterbox_fit_with_bars_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  lfb_pkg::in_item_t  item,
	output logic               rect_valid,
	input  logic               rect_stall,
	output lfb_pkg::out_item_t rect
);

	localparam int D = lfb_pkg::DIM_BITS;
	localparam int P = lfb_pkg::POS_BITS;
	localparam int W = lfb_pkg::PROD_BITS;
	localparam int NS = lfb_pkg::DIV_STAGES;

	function automatic logic [D-1:0] at_least_one(input logic [D-1:0] v);
		return (v == '0) ? {{(D-1){1'b0}}, 1'b1} : v;
	endfunction

	logic adv;

	// stage 1: sanitize, cross products
	lfb_pkg::geo_t g_in;
	logic          v_s1;
	lfb_pkg::geo_t g_s1;
	logic [W-1:0]  pw_s1;
	logic [W-1:0]  ph_s1;

	always_comb begin
		g_in.mx = item.mon_x;
		g_in.my = item.mon_y;
		g_in.mw = at_least_one(item.mon_width);
		g_in.mh = at_least_one(item.mon_height);
		g_in.sw = at_least_one(item.src_width);
		g_in.sh = at_least_one(item.src_height);
		g_in.scale = (g_in.sw > g_in.mw) || (g_in.sh > g_in.mh);
		g_in.wlim = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g_s1 <= g_in;
			pw_s1 <= {{(W-D){1'b0}}, g_in.mw} * {{(W-D){1'b0}}, g_in.sh};
			ph_s1 <= {{(W-D){1'b0}}, g_in.mh} * {{(W-D){1'b0}}, g_in.sw};
		end
	end

	// stage 2: pick limiting side, rounded numerator
	logic          v_s2;
	lfb_pkg::geo_t g_s2;
	logic [W-1:0]  num_s2;
	logic [D-1:0]  d_s2;
	logic          wlim_c;
	logic [D-1:0]  d_c;
	lfb_pkg::geo_t g_c;

	always_comb begin
		wlim_c = pw_s1 <= ph_s1;
		d_c = wlim_c ? g_s1.sw : g_s1.sh;
		g_c = g_s1;
		g_c.wlim = wlim_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g_s2 <= g_c;
			d_s2 <= d_c;
			num_s2 <= (wlim_c ? pw_s1 : ph_s1) + {{(W-D+1){1'b0}}, d_c[D-1:1]};
		end
	end

	// divider stages: restoring division, DIV_STEP quotient bits per stage
	lfb_pkg::div_t dv_sn [NS];
	lfb_pkg::div_t dv_nxt [NS];
	logic [NS-1:0] dv_v_sn;

	always_comb begin
		lfb_pkg::div_t cur;
		logic [D:0]    r2;
		logic [D:0]    diff;
		cur = '0;
		r2 = '0;
		diff = '0;
		for (int k = 0; k < NS; k++) begin
			if (k == 0) begin
				cur.g = g_s2;
				cur.d = d_s2;
				cur.rem = num_s2[W-1:D];
				cur.low = num_s2[D-1:0];
				cur.quo = '0;
			end else begin
				cur = dv_sn[k-1];
			end
			for (int i = 0; i < lfb_pkg::DIV_STEP; i++) begin
				if (k * lfb_pkg::DIV_STEP + i < D) begin
					r2 = {cur.rem, cur.low[D-1]};
					cur.low = {cur.low[D-2:0], 1'b0};
					diff = r2 - {1'b0, cur.d};
					if (r2 >= {1'b0, cur.d}) begin
						cur.rem = diff[D-1:0];
						cur.quo = {cur.quo[D-2:0], 1'b1};
					end else begin
						cur.rem = r2[D-1:0];
						cur.quo = {cur.quo[D-2:0], 1'b0};
					end
				end
			end
			dv_nxt[k] = cur;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NS; k++) begin
				dv_sn[k] <= dv_nxt[k];
			end
		end
	end

	// stage 7: clamp quotient, final size
	logic           v_s7;
	lfb_pkg::size_t sz_s7;
	lfb_pkg::size_t sz_c;
	lfb_pkg::geo_t  gq;
	logic [D-1:0]   q;
	logic [D-1:0]   mlim;
	logic [D-1:0]   qc;

	always_comb begin
		gq = dv_sn[NS-1].g;
		q = dv_sn[NS-1].quo;
		mlim = gq.wlim ? gq.mh : gq.mw;
		priority if (q == '0) begin
			qc = {{(D-1){1'b0}}, 1'b1};
		end else if (q > mlim) begin
			qc = mlim;
		end else begin
			qc = q;
		end
		sz_c.mx = gq.mx;
		sz_c.my = gq.my;
		sz_c.mw = gq.mw;
		sz_c.mh = gq.mh;
		sz_c.w = !gq.scale ? gq.sw : (gq.wlim ? gq.mw : qc);
		sz_c.h = !gq.scale ? gq.sh : (gq.wlim ? qc : gq.mh);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sz_s7 <= sz_c;
		end
	end

	// stage 8: centering, bar geometry
	logic           v_s8;
	lfb_pkg::emit_t em_s8;
	lfb_pkg::emit_t em_c;
	logic [D-1:0]   hgap;
	logic [D-1:0]   wgap;

	always_comb begin
		hgap = sz_s7.mh - sz_s7.h;
		wgap = sz_s7.mw - sz_s7.w;
		em_c.mx = sz_s7.mx;
		em_c.my = sz_s7.my;
		em_c.mw = sz_s7.mw;
		em_c.w = sz_s7.w;
		em_c.h = sz_s7.h;
		em_c.tpad = {1'b0, hgap[D-1:1]};
		em_c.bpad = hgap - {1'b0, hgap[D-1:1]};
		em_c.lpad = {1'b0, wgap[D-1:1]};
		em_c.rpad = wgap - {1'b0, wgap[D-1:1]};
		em_c.px = {1'b0, sz_s7.mx} + {2'b00, wgap[D-1:1]};
		em_c.py = {1'b0, sz_s7.my} + {2'b00, hgap[D-1:1]};
		em_c.ybot = em_c.py + {1'b0, sz_s7.h};
		em_c.xr = em_c.px + {1'b0, sz_s7.w};
		em_c.mask[lfb_pkg::MASK_PIC] = 1'b1;
		em_c.mask[lfb_pkg::MASK_TOP] = hgap[D-1:1] != '0;
		em_c.mask[lfb_pkg::MASK_BOTTOM] = hgap != '0;
		em_c.mask[lfb_pkg::MASK_LEFT] = wgap[D-1:1] != '0;
		em_c.mask[lfb_pkg::MASK_RIGHT] = wgap != '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			em_s8 <= em_c;
		end
	end

	// emitter: one rectangle per cycle into the output register while it is free
	logic                              e_valid_q;
	lfb_pkg::emit_t                    em_q;
	logic [lfb_pkg::MASK_BITS-1:0]     mask_q;
	logic [lfb_pkg::MASK_BITS-1:0]     mask_rest;
	logic                              out_free;
	logic                              e_emit;
	logic                              e_done;
	lfb_pkg::out_item_t                out_nxt;
	logic                              out_valid_q;
	lfb_pkg::out_item_t                out_q;

	always_comb begin
		mask_rest = mask_q & (mask_q - 1'b1);
		out_free = !out_valid_q || !rect_stall;
		e_emit = e_valid_q && out_free;
		e_done = e_emit && (mask_rest == '0);
		adv = !e_valid_q || e_done;
		item_stall = !adv;
	end

	always_comb begin
		out_nxt.last = mask_rest == '0;
		priority if (mask_q[lfb_pkg::MASK_PIC]) begin
			out_nxt.kind = lfb_pkg::KIND_PICTURE;
			out_nxt.rect_x = em_q.px;
			out_nxt.rect_y = em_q.py;
			out_nxt.rect_width = em_q.w;
			out_nxt.rect_height = em_q.h;
		end else if (mask_q[lfb_pkg::MASK_TOP]) begin
			out_nxt.kind = lfb_pkg::KIND_BAR;
			out_nxt.rect_x = {1'b0, em_q.mx};
			out_nxt.rect_y = {1'b0, em_q.my};
			out_nxt.rect_width = em_q.mw;
			out_nxt.rect_height = em_q.tpad;
		end else if (mask_q[lfb_pkg::MASK_BOTTOM]) begin
			out_nxt.kind = lfb_pkg::KIND_BAR;
			out_nxt.rect_x = {1'b0, em_q.mx};
			out_nxt.rect_y = em_q.ybot;
			out_nxt.rect_width = em_q.mw;
			out_nxt.rect_height = em_q.bpad;
		end else if (mask_q[lfb_pkg::MASK_LEFT]) begin
			out_nxt.kind = lfb_pkg::KIND_BAR;
			out_nxt.rect_x = {1'b0, em_q.mx};
			out_nxt.rect_y = em_q.py;
			out_nxt.rect_width = em_q.lpad;
			out_nxt.rect_height = em_q.h;
		end else begin
			out_nxt.kind = lfb_pkg::KIND_BAR;
			out_nxt.rect_x = em_q.xr;
			out_nxt.rect_y = em_q.py;
			out_nxt.rect_width = em_q.rpad;
			out_nxt.rect_height = em_q.h;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			dv_v_sn <= '0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			e_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= item_valid;
				v_s2 <= v_s1;
				dv_v_sn <= {dv_v_sn[NS-2:0], v_s2};
				v_s7 <= dv_v_sn[NS-1];
				v_s8 <= v_s7;
				e_valid_q <= v_s8;
			end
			if (out_free) begin
				out_valid_q <= e_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			em_q <= em_s8;
			mask_q <= em_s8.mask;
		end else if (e_emit) begin
			mask_q <= mask_rest;
		end
		if (e_emit) begin
			out_q <= out_nxt;
		end
	end

	assign rect_valid = out_valid_q;
	assign rect = out_q;

	a_rect_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rect_valid |-> (rect.rect_width != '0) && (rect.rect_height != '0))
		else $error("empty rectangle emitted");

	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		e_valid_q |-> mask_q != '0)
		else $error("emitter holds an item with nothing to send");

	a_bar_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(rect_valid && !rect_stall && !rect.last) |=>
			(rect_valid && rect.kind == lfb_pkg::KIND_BAR))
		else $error("non-final transfer not followed by a bar");

endmodule
